>>> rtl/core/srlr_pkg.sv
package srlr_pkg;

	// Fixed field widths of the transaction payloads.
	localparam int unsigned SET_IN_W  = 11;
	localparam int unsigned WAY_IN_W  = 4;
	localparam int unsigned PC_W      = 10;
	localparam int unsigned ADDR_W    = 64;
	localparam int unsigned STRIDE_W  = 32;
	localparam int unsigned REUSE_W   = 3;
	localparam int unsigned REASON_W  = 2;
	localparam int unsigned THRESH_W  = 3;
	localparam int unsigned IN_DATA_W = 96;
	localparam int unsigned OUT_DATA_W = 8;

	// Signature forming and counter limits.
	localparam int unsigned BLOCK_SHIFT = 6;
	localparam logic [PC_W-1:0] SIG_MASK = 10'h3FF;
	localparam logic [REUSE_W-1:0] REUSE_MAX = 3'd7;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 3'd2;

	// Default geometry.
	localparam int unsigned NUM_SETS_DEF    = 2048;
	localparam int unsigned NUM_WAYS_DEF    = 16;
	localparam int unsigned SIG_ENTRIES_DEF = 1024;

	typedef enum logic {
		OP_VICTIM = 1'b0,
		OP_UPDATE = 1'b1
	} opcode_t;

	typedef enum logic [REASON_W-1:0] {
		REASON_INVALID = 2'd0,
		REASON_REUSE   = 2'd1,
		REASON_LRU     = 2'd2
	} reason_t;

endpackage

>>> rtl/core/srlr_store.sv
module srlr_store #(
	parameter int unsigned NUM_SETS    = 2048,
	parameter int unsigned NUM_WAYS    = 16,
	parameter int unsigned SIG_ENTRIES = 1024,
	parameter int unsigned SW          = 11,
	parameter int unsigned GW          = 10,
	parameter int unsigned AW          = 4
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	output logic                                    clear_busy,
	input  logic                                    rd_en,
	input  logic [SW-1:0]                           set_addr,
	input  logic [GW-1:0]                           sig_addr,
	input  logic                                    row_wr_en,
	input  logic [NUM_WAYS-1:0]                     wr_valid,
	input  logic [NUM_WAYS-1:0][AW-1:0]             wr_age,
	input  logic [NUM_WAYS-1:0][srlr_pkg::REUSE_W-1:0] wr_reuse,
	input  logic [srlr_pkg::ADDR_W-1:0]             wr_last_addr,
	input  logic [srlr_pkg::STRIDE_W-1:0]           wr_stride,
	input  logic                                    sig_wr_en,
	input  logic [srlr_pkg::REUSE_W-1:0]            wr_cnt,
	output logic [NUM_WAYS-1:0]                     rd_valid,
	output logic [NUM_WAYS-1:0][AW-1:0]             rd_age,
	output logic [NUM_WAYS-1:0][srlr_pkg::REUSE_W-1:0] rd_reuse,
	output logic [srlr_pkg::ADDR_W-1:0]             rd_last_addr,
	output logic [srlr_pkg::STRIDE_W-1:0]           rd_stride,
	output logic [srlr_pkg::REUSE_W-1:0]            rd_cnt
);
	import srlr_pkg::*;

	localparam int unsigned CLR_LEN = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
	localparam int unsigned CW = $clog2(CLR_LEN + 1);

	logic [NUM_WAYS-1:0]               valid_mem [NUM_SETS];
	logic [NUM_WAYS-1:0][AW-1:0]       age_mem   [NUM_SETS];
	logic [NUM_WAYS-1:0][REUSE_W-1:0]  reuse_mem [NUM_SETS];
	logic [ADDR_W-1:0]                 laddr_mem [NUM_SETS];
	logic [STRIDE_W-1:0]               stride_mem[NUM_SETS];
	logic [REUSE_W-1:0]                cnt_mem   [SIG_ENTRIES];

	logic [CW-1:0] clr_q;
	logic          busy_q;
	logic [NUM_WAYS-1:0][AW-1:0] age_init;

	assign clear_busy = busy_q;

	// Reset ages of a row are the way numbers.
	always_comb begin
		for (int i = 0; i < NUM_WAYS; i++) begin
			age_init[i] = AW'(i);
		end
	end

	// Clearing sweep after reset, one row and one counter per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == CW'(CLR_LEN - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Per-set storage: row of way states and stride history.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (clr_q < CW'(NUM_SETS)) begin
				valid_mem[SW'(clr_q)]  <= '0;
				age_mem[SW'(clr_q)]    <= age_init;
				reuse_mem[SW'(clr_q)]  <= '0;
				laddr_mem[SW'(clr_q)]  <= '0;
				stride_mem[SW'(clr_q)] <= '0;
			end
		end else if (row_wr_en) begin
			valid_mem[set_addr]  <= wr_valid;
			age_mem[set_addr]    <= wr_age;
			reuse_mem[set_addr]  <= wr_reuse;
			laddr_mem[set_addr]  <= wr_last_addr;
			stride_mem[set_addr] <= wr_stride;
		end
		if (rd_en) begin
			rd_valid     <= valid_mem[set_addr];
			rd_age       <= age_mem[set_addr];
			rd_reuse     <= reuse_mem[set_addr];
			rd_last_addr <= laddr_mem[set_addr];
			rd_stride    <= stride_mem[set_addr];
		end
	end

	// Signature counter table.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (clr_q < CW'(SIG_ENTRIES)) begin
				cnt_mem[GW'(clr_q)] <= '0;
			end
		end else if (sig_wr_en) begin
			cnt_mem[sig_addr] <= wr_cnt;
		end
		if (rd_en) begin
			rd_cnt <= cnt_mem[sig_addr];
		end
	end

endmodule

>>> rtl/core/signature_reuse_lru_replacement.sv
// Victim query: reduce, read, then scan, where the shared compare unit steps through the
// ways of the set one at a time (stopping early if the row holds an invalid way), then done.
// Update: reduce, read the row, then write it back. One transaction at a time.
// A set index or signature beyond the table size is reduced by subtracting the table length.
// After arst_n the block clears every row and signature counter,
// accepting no transaction; the threshold register resets to 2.
module signature_reuse_lru_replacement #(
	parameter int unsigned NUM_SETS    = srlr_pkg::NUM_SETS_DEF,
	parameter int unsigned NUM_WAYS    = srlr_pkg::NUM_WAYS_DEF,
	parameter int unsigned SIG_ENTRIES = srlr_pkg::SIG_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// set_index[10:0], way[14:11], pc_low[24:15], address[88:25], hit[89], zero fill
	input  logic [srlr_pkg::IN_DATA_W-1:0]     s_tdata,
	// opcode[0]
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// victim_way[3:0], zero fill
	output logic [srlr_pkg::OUT_DATA_W-1:0]    m_tdata,
	// victim_reason[1:0]
	output logic [srlr_pkg::REASON_W-1:0]      m_tuser,
	input  logic                               cfg_wr_en,
	input  logic [srlr_pkg::THRESH_W-1:0]      cfg_wr_data
);
	import srlr_pkg::*;

	localparam int unsigned SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int unsigned GW = $clog2(SIG_ENTRIES);
	localparam int unsigned AW = $clog2(NUM_WAYS);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_REDUCE = 7'b0000100,
		ST_READ   = 7'b0001000,
		ST_SCAN   = 7'b0010000,
		ST_UPD    = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [THRESH_W-1:0] thresh_q;
	logic                op_q;
	logic [SET_IN_W-1:0] set_q;
	logic [WAY_IN_W-1:0] way_q;
	logic [PC_W-1:0]     sig_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                hit_q;

	logic [AW-1:0]       idx_q;
	logic [AW-1:0]       best_q, lru_q;
	logic [REUSE_W-1:0]  best_r_q;
	logic [AW-1:0]       best_a_q, lru_a_q;
	logic [AW-1:0]       res_way_q;
	reason_t             res_reason_q;

	logic                m_valid_q;
	logic [WAY_IN_W-1:0] m_way_q;
	reason_t             m_reason_q;

	logic                clear_busy;
	logic                rd_en, row_wr_en, sig_wr_en;
	logic [NUM_WAYS-1:0] rd_valid, wr_valid;
	logic [NUM_WAYS-1:0][AW-1:0] rd_age, wr_age;
	logic [NUM_WAYS-1:0][REUSE_W-1:0] rd_reuse, wr_reuse;
	logic [ADDR_W-1:0]   rd_last_addr;
	logic [STRIDE_W-1:0] rd_stride, wr_stride, stride;
	logic [REUSE_W-1:0]  rd_cnt, new_cnt, line_reuse;
	logic                set_big, sig_big, way_ok, in_acc, last_nz, bump;
	logic                any_invalid;
	logic [AW-1:0]       first_inv, upd_way;
	logic [REUSE_W-1:0]  cur_r;
	logic [AW-1:0]       cur_a, old_age;
	logic                take_best, take_lru;
	logic [AW-1:0]       nbest, nlru;
	logic [REUSE_W-1:0]  nbest_r;
	logic [AW-1:0]       nbest_a, nlru_a;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_W'(m_way_q);
	assign m_tuser  = m_reason_q;

	// Range reduction of the set index and the signature.
	assign set_big = 32'(set_q) >= 32'(NUM_SETS);
	assign sig_big = 32'(sig_q) >= 32'(SIG_ENTRIES);
	assign way_ok  = {2'b00, way_q} < 6'(NUM_WAYS);

	srlr_store #(
		.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SIG_ENTRIES(SIG_ENTRIES),
		.SW(SW), .GW(GW), .AW(AW)
	) u_store (
		.clk(clk), .arst_n(arst_n), .clear_busy(clear_busy),
		.rd_en(rd_en), .set_addr(SW'(set_q)), .sig_addr(GW'(sig_q)),
		.row_wr_en(row_wr_en), .wr_valid(wr_valid), .wr_age(wr_age),
		.wr_reuse(wr_reuse), .wr_last_addr(addr_q), .wr_stride(wr_stride),
		.sig_wr_en(sig_wr_en), .wr_cnt(new_cnt),
		.rd_valid(rd_valid), .rd_age(rd_age), .rd_reuse(rd_reuse),
		.rd_last_addr(rd_last_addr), .rd_stride(rd_stride), .rd_cnt(rd_cnt)
	);

	// First invalid way of the row.
	always_comb begin
		first_inv = '0;
		for (int i = NUM_WAYS - 1; i >= 0; i--) begin
			if (!rd_valid[i]) begin
				first_inv = AW'(i);
			end
		end
	end
	assign any_invalid = !(&rd_valid);

	// Shared compare unit: one way per cycle against the running best and oldest.
	assign cur_r     = rd_reuse[idx_q];
	assign cur_a     = rd_age[idx_q];
	assign take_best = (idx_q == '0) || (cur_r < best_r_q) ||
		((cur_r == best_r_q) && (cur_a > best_a_q));
	assign take_lru  = (idx_q == '0) || (cur_a > lru_a_q);
	assign nbest     = take_best ? idx_q : best_q;
	assign nbest_r   = take_best ? cur_r : best_r_q;
	assign nbest_a   = take_best ? cur_a : best_a_q;
	assign nlru      = take_lru ? idx_q : lru_q;
	assign nlru_a    = take_lru ? cur_a : lru_a_q;

	// Update datapath: counter, stride check and new row contents.
	assign upd_way = AW'(way_q);
	assign old_age = rd_age[upd_way];
	assign stride  = addr_q[STRIDE_W-1:0] - rd_last_addr[STRIDE_W-1:0];
	assign last_nz = (rd_last_addr != '0);
	assign bump    = last_nz && (stride == rd_stride) && (stride != '0);
	always_comb begin
		if (hit_q) begin
			new_cnt = (rd_cnt < REUSE_MAX) ? rd_cnt + 1'b1 : rd_cnt;
		end else begin
			new_cnt = (rd_cnt != '0) ? rd_cnt - 1'b1 : rd_cnt;
		end
		line_reuse = (bump && new_cnt < REUSE_MAX) ? new_cnt + 1'b1 : new_cnt;
		wr_valid   = rd_valid;
		wr_age     = rd_age;
		wr_reuse   = rd_reuse;
		for (int i = 0; i < NUM_WAYS; i++) begin
			if (rd_age[i] < old_age) begin
				wr_age[i] = rd_age[i] + 1'b1;
			end
		end
		wr_age[upd_way]   = '0;
		wr_reuse[upd_way] = line_reuse;
		wr_valid[upd_way] = 1'b1;
		wr_stride = last_nz ? stride : rd_stride;
	end

	assign rd_en     = (state_q == ST_READ);
	assign row_wr_en = (state_q == ST_UPD);
	assign sig_wr_en = (state_q == ST_UPD);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (!clear_busy) state_d = ST_IDLE;
			ST_IDLE:   if (in_acc) state_d = ST_REDUCE;
			ST_REDUCE: begin
				if (!set_big && !sig_big) begin
					if (op_q == OP_VICTIM || way_ok) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_READ:   state_d = (op_q == OP_VICTIM) ? ST_SCAN : ST_UPD;
			ST_SCAN: begin
				if (any_invalid || idx_q == AW'(NUM_WAYS - 1)) state_d = ST_DONE;
			end
			ST_UPD:    state_d = ST_IDLE;
			ST_DONE:   if (!m_valid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			thresh_q <= THRESH_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				thresh_q <= cfg_wr_data;
			end
		end
	end

	// Captured transaction and range reduction.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= s_tuser;
			set_q  <= s_tdata[10:0];
			way_q  <= s_tdata[14:11];
			sig_q  <= (s_tdata[24:15] ^ s_tdata[25+BLOCK_SHIFT +: PC_W]) & SIG_MASK;
			addr_q <= s_tdata[88:25];
			hit_q  <= s_tdata[89];
		end else if (state_q == ST_REDUCE) begin
			if (set_big) set_q <= set_q - SET_IN_W'(NUM_SETS);
			if (sig_big) sig_q <= sig_q - PC_W'(SIG_ENTRIES);
		end
	end

	// Way scan registers and the decision at the last way scanned.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			idx_q <= '0;
		end else if (state_q == ST_SCAN) begin
			idx_q    <= idx_q + 1'b1;
			best_q   <= nbest;
			best_r_q <= nbest_r;
			best_a_q <= nbest_a;
			lru_q    <= nlru;
			lru_a_q  <= nlru_a;
			if (any_invalid) begin
				res_way_q    <= first_inv;
				res_reason_q <= REASON_INVALID;
			end else if (nbest_r <= thresh_q) begin
				res_way_q    <= nbest;
				res_reason_q <= REASON_REUSE;
			end else begin
				res_way_q    <= nlru;
				res_reason_q <= REASON_LRU;
			end
		end
	end

	// Output register: holds a result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!m_valid_q || m_tready)) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!m_valid_q || m_tready)) begin
			m_way_q    <= WAY_IN_W'(res_way_q);
			m_reason_q <= res_reason_q;
		end
	end

endmodule

>>> tb/sv/tb_signature_reuse_lru_replacement.sv
`timescale 1ns / 100ps

module tb_signature_reuse_lru_replacement;
	import srlr_pkg::*;

	localparam int unsigned SETS = NUM_SETS_DEF;
	localparam int unsigned WAYS = NUM_WAYS_DEF;
	localparam int unsigned SIGS = SIG_ENTRIES_DEF;
	localparam int unsigned SETTLE_CYCLES = WAYS + 12;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [WAY_IN_W-1:0] way;
		reason_t reason;
	} victim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [REASON_W-1:0] m_tuser;
	logic cfg_wr_en = 1'b0;
	logic [THRESH_W-1:0] cfg_wr_data = '0;

	// Shadow copy of the replacement state.
	bit line_valid_q [SETS][WAYS];
	bit [3:0] line_age_q [SETS][WAYS];
	bit [REUSE_W-1:0] line_reuse_q [SETS][WAYS];
	bit [REUSE_W-1:0] sig_count_q [SIGS];
	bit [ADDR_W-1:0] last_addr_q [SETS];
	bit [STRIDE_W-1:0] last_stride_q [SETS];
	bit [THRESH_W-1:0] threshold_q;

	victim_t pending_victims [$];
	int unsigned mismatches = 0;
	longint unsigned cycle_count = 0;
	bit quiet_sender = 1'b0;
	bit quiet_receiver = 1'b0;
	int unsigned receiver_stall = 0;

	signature_reuse_lru_replacement dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("signature_reuse_lru_replacement regression: fail");
			$finish;
		end
	end

	// Receiver readiness with random stalls after each accepted result.
	always @(posedge clk) begin
		int unsigned n;
		if (m_tvalid && m_tready) begin
			n = quiet_receiver ? 0 : $urandom_range(0, 6);
			receiver_stall <= n;
			m_tready <= (n == 0);
		end else if (receiver_stall > 0) begin
			receiver_stall <= receiver_stall - 1;
			m_tready <= (receiver_stall == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result transaction with the oldest predicted victim.
	always @(posedge clk) begin
		victim_t exp_v;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_victims.size() == 0) begin
				$error("unexpected result: victim_way %0d reason %0d", m_tdata, m_tuser);
				mismatches++;
			end else begin
				exp_v = pending_victims.pop_front();
				if (m_tdata !== {{(OUT_DATA_W-WAY_IN_W){1'b0}}, exp_v.way}) begin
					$error("victim_way: expected %0d, got %0d", exp_v.way, m_tdata);
					mismatches++;
				end
				if (m_tuser !== exp_v.reason) begin
					$error("victim_reason: expected %0d, got %0d", exp_v.reason, m_tuser);
					mismatches++;
				end
			end
		end
	end

	function automatic void reset_shadow();
		for (int s = 0; s < SETS; s++) begin
			for (int w = 0; w < WAYS; w++) begin
				line_valid_q[s][w] = 1'b0;
				line_age_q[s][w] = 4'(w);
				line_reuse_q[s][w] = '0;
			end
			last_addr_q[s] = '0;
			last_stride_q[s] = '0;
		end
		for (int i = 0; i < SIGS; i++)
			sig_count_q[i] = '0;
		threshold_q = THRESH_RESET;
	endfunction

	// Invalid way first, then lowest reuse (oldest age on a tie) if within the threshold, else true LRU.
	function automatic victim_t choose_victim(int unsigned s);
		victim_t v;
		int unsigned best;
		int unsigned best_reuse;
		int unsigned best_age;
		best = 0;
		best_reuse = line_reuse_q[s][0];
		best_age = line_age_q[s][0];
		for (int w = 0; w < WAYS; w++) begin
			if (!line_valid_q[s][w]) begin
				v.way = WAY_IN_W'(w);
				v.reason = REASON_INVALID;
				return v;
			end
		end
		for (int w = 1; w < WAYS; w++) begin
			if (line_reuse_q[s][w] < best_reuse ||
					(line_reuse_q[s][w] == best_reuse && line_age_q[s][w] > best_age)) begin
				best = w;
				best_reuse = line_reuse_q[s][w];
				best_age = line_age_q[s][w];
			end
		end
		if (best_reuse <= threshold_q) begin
			v.way = WAY_IN_W'(best);
			v.reason = REASON_REUSE;
			return v;
		end
		best = 0;
		best_age = line_age_q[s][0];
		for (int w = 1; w < WAYS; w++) begin
			if (line_age_q[s][w] > best_age) begin
				best = w;
				best_age = line_age_q[s][w];
			end
		end
		v.way = WAY_IN_W'(best);
		v.reason = REASON_LRU;
		return v;
	endfunction

	// Signature training, MRU promotion and stride-based reuse bump.
	function automatic void train_line(int unsigned s, int unsigned w, bit [PC_W-1:0] pc,
			bit [ADDR_W-1:0] addr, bit hit);
		bit [PC_W-1:0] sig;
		bit [REUSE_W-1:0] cnt;
		bit [3:0] old_age;
		bit [STRIDE_W-1:0] stride;
		sig = (pc ^ addr[BLOCK_SHIFT +: PC_W]) & SIG_MASK;
		cnt = sig_count_q[sig % SIGS];
		if (hit && cnt != REUSE_MAX)
			cnt++;
		else if (!hit && cnt != 0)
			cnt--;
		sig_count_q[sig % SIGS] = cnt;
		line_reuse_q[s][w] = cnt;
		old_age = line_age_q[s][w];
		for (int i = 0; i < WAYS; i++)
			if (line_age_q[s][i] < old_age)
				line_age_q[s][i]++;
		line_age_q[s][w] = 0;
		if (last_addr_q[s] != 0) begin
			stride = STRIDE_W'(addr - last_addr_q[s]);
			if (stride == last_stride_q[s] && stride != 0 && line_reuse_q[s][w] != REUSE_MAX)
				line_reuse_q[s][w]++;
			last_stride_q[s] = stride;
		end
		last_addr_q[s] = addr;
		line_valid_q[s][w] = 1'b1;
	endfunction

	// Send one transaction after a random gap; valid stays high if the next follows at once.
	task automatic send_item(opcode_t op, bit [SET_IN_W-1:0] set_idx, bit [WAY_IN_W-1:0] way,
			bit [PC_W-1:0] pc, bit [ADDR_W-1:0] addr, bit hit);
		int unsigned gap;
		gap = quiet_sender ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, hit, addr, pc, way, set_idx};
		do @(posedge clk); while (!s_tready);
		if (op == OP_VICTIM)
			pending_victims.push_back(choose_victim(set_idx % SETS));
		else if (way < WAYS)
			train_line(set_idx % SETS, way, pc, addr, hit);
	endtask

	// Stop sending and wait until every predicted result has been seen.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_victims.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(bit [THRESH_W-1:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		threshold_q = value;
	endtask

	// Empty sets, field extremes and a full set.
	task automatic test_directed();
		send_item(OP_VICTIM, 0, 0, 0, 0, 0);
		send_item(OP_VICTIM, 11'h7FF, 4'hF, 10'h3FF, '1, 1);
		send_item(OP_UPDATE, 11'h7FF, 4'hF, 10'h3FF, '1, 1);
		send_item(OP_UPDATE, 11'h7FF, 4'h0, 10'h000, 64'h0, 0);
		send_item(OP_VICTIM, 11'h7FF, 0, 0, 0, 0);
		for (int w = 0; w < WAYS; w++)
			send_item(OP_UPDATE, 5, WAY_IN_W'(WAYS - 1 - w), PC_W'(w), 64'h1000 + w * 64,
				w[0]);
		send_item(OP_VICTIM, 5, 0, 0, 0, 0);
		send_item(OP_VICTIM, 5, 0, 0, 0, 0);
		drain();
	endtask

	// Equal strides in one set bump reuse.
	task automatic test_stride();
		for (int k = 0; k < 24; k++)
			send_item(OP_UPDATE, 9, WAY_IN_W'(k % WAYS), 10'h155, 64'h8000 + k * 64'h40, 1);
		send_item(OP_VICTIM, 9, 0, 0, 0, 0);
		drain();
	endtask

	// Random mix concentrated on a few sets so they fill and exercise reuse eviction.
	task automatic test_random(int unsigned count);
		bit [ADDR_W-1:0] base [8];
		bit [ADDR_W-1:0] step [8];
		bit [THRESH_W-1:0] levels [8] = '{0, 7, 2, 5, 1, 7, 3, 0};
		bit [SET_IN_W-1:0] set_idx;
		bit [ADDR_W-1:0] addr;
		int unsigned slot;
		for (int i = 0; i < 8; i++) begin
			base[i] = {$urandom, $urandom};
			step[i] = 64'h40 << $urandom_range(0, 4);
		end
		for (int n = 0; n < count; n++) begin
			if (n % 160 == 0) begin
				write_threshold(levels[(n / 160) % 8]);
				quiet_sender = ((n / 160) % 3 == 1);
				quiet_receiver = ((n / 160) % 3 == 2);
			end
			slot = $urandom_range(0, 7);
			if ($urandom_range(0, 99) < 15)
				set_idx = SET_IN_W'($urandom);
			else
				set_idx = SET_IN_W'(100 + slot);
			case ($urandom_range(0, 9))
				0: addr = {$urandom, $urandom};
				1: addr = '0;
				default: begin
					base[slot] = base[slot] + step[slot];
					addr = base[slot];
				end
			endcase
			if ($urandom_range(0, 99) < 40)
				send_item(OP_VICTIM, set_idx, WAY_IN_W'($urandom), PC_W'($urandom), addr,
					1'($urandom));
			else
				send_item(OP_UPDATE, set_idx, WAY_IN_W'($urandom), PC_W'($urandom), addr,
					$urandom_range(0, 3) != 0);
		end
		drain();
	endtask

	initial begin
		reset_shadow();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_stride();
		test_random(1300);
		quiet_sender = 1'b0;
		quiet_receiver = 1'b0;
		if (mismatches == 0)
			$display("signature_reuse_lru_replacement regression: pass");
		else
			$display("signature_reuse_lru_replacement regression: fail");
		$finish;
	end

endmodule
